// ===== hdl/itok_pkg.sv =====
// Types and constants shared by the expression tokenizer modules.
// No dependencies.
`timescale 1ns / 1ps

package itok_pkg;

    typedef enum logic [2:0] {
        KIND_INT   = 3'd0,
        KIND_ADDR  = 3'd1,
        KIND_WCHAR = 3'd2,
        KIND_WEND  = 3'd3,
        KIND_SYM   = 3'd4,
        KIND_EOL   = 3'd5
    } tok_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_WORD = 2'd2
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        tok_kind_t   token_kind;
        logic [31:0] value;
        logic [7:0]  char_out;
        logic [11:0] start_pos;
        logic        last_result;
    } out_item_t;

    // One result before it is given its place in the output order
    typedef struct packed {
        tok_kind_t   kind;
        logic [31:0] value;
        logic [7:0]  char_out;
        logic [11:0] start_pos;
    } res_t;

    localparam int NSLOT = 4;

    // All results of one item: close, char, close at line end, line end
    typedef struct packed {
        logic [NSLOT-1:0] valid;
        res_t [NSLOT-1:0] slot;
    } bundle_t;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Digit runs of this length starting with 0, 1, 3 or 4 may be addresses
    localparam int ADDR_DIGITS = 6;

endpackage

// ===== hdl/itok_front.sv =====
// Front end of the tokenizer: classifies each character, keeps the lexer
// state and builds the bundle of results for the item. Uses itok_pkg.
`timescale 1ns / 1ps

module itok_front #(
    parameter int MAX_LINE = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  itok_pkg::in_item_t item,
    output itok_pkg::bundle_t  bundle,
    output logic               bundle_valid
);
    import itok_pkg::*;

    localparam int POS_W = $clog2(MAX_LINE);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);

    lex_mode_t        mode_reg, mode_next;
    logic [31:0]      acc_reg, acc_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [3:0]       first_reg, first_next;
    logic             tnz_reg, tnz_next;
    logic [POS_W-1:0] tstart_reg, tstart_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic             is_dig, is_alpha, is_space, is_word;
    logic [3:0]       dig;
    logic [7:0]       upper;
    logic [35:0]      prod;
    logic [31:0]      acc_sat;
    bundle_t          b;

    function automatic logic [11:0] pos12(input logic [POS_W-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[11:0];
    endfunction

    function automatic res_t close_res(
        input lex_mode_t        m,
        input logic [31:0]      acc,
        input logic [2:0]       cnt,
        input logic [3:0]       first,
        input logic             tnz,
        input logic [POS_W-1:0] start
    );
        res_t r;
        r = '0;
        r.start_pos = pos12(start);
        if (m == MODE_NUM) begin
            r.value = acc;
            // a six-digit value is below 10^6, so a nonzero tail means mod 10^5 != 0
            if (cnt == 3'(ADDR_DIGITS) && tnz &&
                (first == 4'd0 || first == 4'd1 || first == 4'd3 || first == 4'd4))
                r.kind = KIND_ADDR;
            else
                r.kind = KIND_INT;
        end
        else begin
            r.kind = KIND_WEND;
        end
        return r;
    endfunction

    assign is_dig   = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
    assign is_alpha = (item.ch >= 8'h41 && item.ch <= 8'h5A) ||
                      (item.ch >= 8'h61 && item.ch <= 8'h7A);
    assign is_space = (item.ch == 8'h20) || (item.ch >= 8'h09 && item.ch <= 8'h0D);
    assign is_word  = is_alpha || is_dig || (item.ch == CH_UNDER);
    assign dig      = item.ch[3:0];
    assign upper    = (item.ch >= 8'h61 && item.ch <= 8'h7A) ? (item.ch & 8'hDF) : item.ch;

    // acc * 10 + digit, held at all ones on overflow
    assign prod    = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {32'd0, dig};
    assign acc_sat = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];

    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        tnz_next    = tnz_reg;
        tstart_next = tstart_reg;
        pos_next    = pos_reg;
        b           = '0;

        if (item.has_char) begin
            if ((mode_reg == MODE_NUM && !is_dig) || (mode_reg == MODE_WORD && !is_word)) begin
                b.valid[0] = 1'b1;
                b.slot[0]  = close_res(mode_reg, acc_reg, cnt_reg, first_reg, tnz_reg,
                                       tstart_reg);
                mode_next  = MODE_IDLE;
                acc_next   = '0;
                cnt_next   = '0;
                first_next = '0;
                tnz_next   = 1'b0;
            end

            unique case (mode_next)
                MODE_NUM:
                begin
                    acc_next = acc_sat;
                    cnt_next = (cnt_reg == 3'd7) ? cnt_reg : cnt_reg + 3'd1;
                    tnz_next = tnz_reg | (dig != 4'd0);
                end
                MODE_WORD:
                begin
                    b.valid[1]          = 1'b1;
                    b.slot[1].kind      = KIND_WCHAR;
                    b.slot[1].char_out  = upper;
                    b.slot[1].start_pos = pos12(tstart_reg);
                end
                default:
                begin
                    priority if (is_space) begin
                        // skip
                    end
                    else if (is_dig) begin
                        mode_next   = MODE_NUM;
                        tstart_next = pos_reg;
                        acc_next    = {28'd0, dig};
                        cnt_next    = 3'd1;
                        first_next  = dig;
                        tnz_next    = 1'b0;
                    end
                    else if (is_alpha || item.ch == CH_UNDER) begin
                        mode_next           = MODE_WORD;
                        tstart_next         = pos_reg;
                        b.valid[1]          = 1'b1;
                        b.slot[1].kind      = KIND_WCHAR;
                        b.slot[1].char_out  = upper;
                        b.slot[1].start_pos = pos12(pos_reg);
                    end
                    else begin
                        b.valid[1]          = 1'b1;
                        b.slot[1].kind      = KIND_SYM;
                        b.slot[1].char_out  = item.ch;
                        b.slot[1].start_pos = pos12(pos_reg);
                    end
                end
            endcase

            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
        end

        if (item.end_of_line) begin
            if (mode_next != MODE_IDLE) begin
                b.valid[2] = 1'b1;
                b.slot[2]  = close_res(mode_next, acc_next, cnt_next, first_next, tnz_next,
                                       tstart_next);
            end
            b.valid[3]     = 1'b1;
            b.slot[3].kind = KIND_EOL;
            mode_next      = MODE_IDLE;
            acc_next       = '0;
            cnt_next       = '0;
            first_next     = '0;
            tnz_next       = 1'b0;
            tstart_next    = '0;
            pos_next       = '0;
        end
    end

    assign bundle       = b;
    assign bundle_valid = accept && (b.valid != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_IDLE;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            first_reg  <= '0;
            tnz_reg    <= 1'b0;
            tstart_reg <= '0;
            pos_reg    <= '0;
        end
        else if (accept) begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            first_reg  <= first_next;
            tnz_reg    <= tnz_next;
            tstart_reg <= tstart_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

// ===== hdl/itok_queue.sv =====
// Short queue of result bundles between the tokenizer front and back ends.
// Uses itok_pkg.
`timescale 1ns / 1ps

module itok_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  itok_pkg::bundle_t wr_data,
    input  logic              rd_en,
    output itok_pkg::bundle_t rd_data,
    output logic              full,
    output logic              empty
);
    import itok_pkg::*;

    bundle_t           mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== hdl/itok_back.sv =====
// Back end of the tokenizer: holds one bundle and hands out its results
// one item at a time, oldest slot first. Uses itok_pkg.
`timescale 1ns / 1ps

module itok_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  itok_pkg::bundle_t   q_data,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output itok_pkg::out_item_t token
);
    import itok_pkg::*;

    logic [NSLOT-1:0] mask_reg, mask_next;
    res_t [NSLOT-1:0] slot_reg, slot_next;
    logic [NSLOT-1:0] pick;
    logic [NSLOT-1:0] rest;
    logic             load;
    res_t             cur;

    always_comb
    begin
        pick = '0;
        cur  = slot_reg[0];
        priority if (mask_reg[0]) begin
            pick[0] = 1'b1;
            cur     = slot_reg[0];
        end
        else if (mask_reg[1]) begin
            pick[1] = 1'b1;
            cur     = slot_reg[1];
        end
        else if (mask_reg[2]) begin
            pick[2] = 1'b1;
            cur     = slot_reg[2];
        end
        else if (mask_reg[3]) begin
            pick[3] = 1'b1;
            cur     = slot_reg[3];
        end
        else begin
            pick = '0;
        end
    end

    assign rest  = mask_reg & ~pick;
    assign empty = (mask_reg == '0);
    // refill once the held bundle is drained or about to be
    assign load  = empty || (pop && rest == '0);
    assign q_pop = load && !q_empty;

    always_comb
    begin
        mask_next = mask_reg;
        slot_next = slot_reg;
        if (load) begin
            mask_next = q_empty ? '0 : q_data.valid;
            slot_next = q_data.slot;
        end
        else if (pop) begin
            mask_next = rest;
        end
    end

    assign token.token_kind  = cur.kind;
    assign token.value       = cur.value;
    assign token.char_out    = cur.char_out;
    assign token.start_pos   = cur.start_pos;
    assign token.last_result = (rest == '0);

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

endmodule

// ===== hdl/item_expression_tokenizer.sv =====
// Expression tokenizer, one character item per cycle while full is low.
// The results of an item pass through a four-bundle queue and then the back
// end's bundle register, and leave by the token port one result per pop; an
// item with more than one result holds the port while the queue takes more.
// Reset clears the lexer state and empties the queue at once.
`timescale 1ns / 1ps

module item_expression_tokenizer #(
    parameter int MAX_LINE = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  itok_pkg::in_item_t  char_item,
    output logic                empty,
    input  logic                pop,
    output itok_pkg::out_item_t token
);
    import itok_pkg::*;

    logic    accept;
    bundle_t f_bundle;
    logic    f_valid;
    bundle_t q_data;
    logic    q_empty;
    logic    q_pop;

    assign accept = push && !full;

    itok_front #(
        .MAX_LINE(MAX_LINE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (char_item),
        .bundle       (f_bundle),
        .bundle_valid (f_valid)
    );

    itok_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid),
        .wr_data (f_bundle),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    itok_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .token   (token)
    );

endmodule
